FILE: rtl/mmbd_pkg.sv
// Shared types and constants for the min/max bucket decimator.
// Used by the bucket datapath, the result queue and the top level.
// No dependencies.
package mmbd_pkg;

  // Kind of a result transaction.
  typedef enum logic [1:0] {
    KIND_PASS = 2'd0,
    KIND_MIN  = 2'd1,
    KIND_MAX  = 2'd2
  } kind_t;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 2;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_SAMPLE_COUNT = 2'd0;
  localparam cfg_idx_t REG_POINT_BUDGET = 2'd1;

  // Reset value of the point budget register.
  localparam int BUDGET_RESET = 10000;

  // Result queue depth and the most results one sample can cause.
  localparam int RESULT_DEPTH = 8;
  localparam int MAX_PUSH     = 2;

endpackage

FILE: rtl/mmbd_div.sv
// Restoring divider for the bucket setup: sample count over bucket total.
// One quotient bit per cycle. Depends on nothing outside this file.
module mmbd_div #(
  parameter int COUNT_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [COUNT_BITS:0]   dividend,
  input  logic [COUNT_BITS-1:0] divisor,
  output logic                  busy,
  output logic                  done,
  output logic [COUNT_BITS:0]   quotient,
  output logic [COUNT_BITS-1:0] remainder
);

  localparam int NW   = COUNT_BITS + 1;
  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]         quo;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS-1:0] dvs;
  logic [CNTW-1:0]       steps;
  logic [COUNT_BITS:0]   shifted;
  logic [COUNT_BITS:0]   diff;
  logic                  fits;

  // One trial subtraction per cycle.
  always_comb begin
    shifted = {rem, quo[NW-1]};
    diff    = shifted - {1'b0, dvs};
    fits    = shifted >= {1'b0, dvs};
  end

  // Control: a start reloads the operands and aborts any division in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= CNTW'(NW);
      end else if (busy) begin
        steps <= steps - CNTW'(1);
        if (steps == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient shifts in from the right, remainder stays below the divisor.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[NW-2:0], fits};
      rem <= fits ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

FILE: rtl/mmbd_bucket.sv
// Bucket state and result generation: running min/max, position and boundary.
// Uses kind_t from mmbd_pkg; the setup quotient comes from mmbd_div.
module mmbd_bucket
  import mmbd_pkg::*;
#(
  parameter int SAMPLE_BITS = 32,
  parameter int COUNT_BITS  = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic signed [SAMPLE_BITS-1:0] item_sample,
  input  logic                          item_gap,
  input  logic                          decimating,
  input  logic [COUNT_BITS:0]           sample_count,
  input  logic [COUNT_BITS-1:0]         bucket_total,
  input  logic                          setup_done,
  input  logic [COUNT_BITS:0]           setup_quotient,
  input  logic [COUNT_BITS-1:0]         setup_remainder,
  output logic                          push_first,
  output logic                          push_second,
  output logic signed [SAMPLE_BITS-1:0] first_value,
  output logic                          first_gap,
  output kind_t                         first_kind,
  output logic                          first_last,
  output logic signed [SAMPLE_BITS-1:0] second_value,
  output logic                          second_gap
);

  localparam int NW = COUNT_BITS + 1;

  logic [NW-1:0]                 position;
  logic [NW-1:0]                 bucket_end;
  logic [COUNT_BITS-1:0]         boundary_rem;
  logic [NW-1:0]                 step_q;
  logic [COUNT_BITS-1:0]         step_r;
  logic signed [SAMPLE_BITS-1:0] running_min;
  logic signed [SAMPLE_BITS-1:0] running_max;
  logic                          seen_valid;

  logic signed [SAMPLE_BITS-1:0] min_next;
  logic signed [SAMPLE_BITS-1:0] max_next;
  logic                          seen_next;
  logic [NW-1:0]                 position_next;
  logic                          bucket_hit;
  logic                          series_end;
  logic [COUNT_BITS:0]           rem_sum;
  logic                          rem_carry;
  logic [COUNT_BITS-1:0]         boundary_rem_next;
  logic [NW-1:0]                 bucket_end_next;

  // Fold the current sample into the running extremes; gaps are skipped.
  always_comb begin
    min_next  = running_min;
    max_next  = running_max;
    if (!item_gap && (!seen_valid || item_sample < running_min)) begin
      min_next = item_sample;
    end
    if (!item_gap && (!seen_valid || running_max < item_sample)) begin
      max_next = item_sample;
    end
    seen_next = seen_valid | ~item_gap;
  end

  // Position and next boundary: quotient plus a carry from the remainder sum.
  always_comb begin
    position_next     = position + NW'(1);
    bucket_hit        = position_next >= bucket_end;
    series_end        = position_next >= sample_count;
    rem_sum           = {1'b0, boundary_rem} + {1'b0, step_r};
    rem_carry         = rem_sum >= {1'b0, bucket_total};
    boundary_rem_next = rem_carry ? COUNT_BITS'(rem_sum - {1'b0, bucket_total})
                                  : rem_sum[COUNT_BITS-1:0];
    bucket_end_next   = bucket_end + step_q + NW'(rem_carry);
  end

  // Result transactions for this sample.
  always_comb begin
    push_first   = item_valid && (!decimating || bucket_hit);
    push_second  = item_valid && decimating && bucket_hit;
    second_value = seen_next ? max_next : '0;
    second_gap   = ~seen_next;
    if (!decimating) begin
      first_value = item_gap ? '0 : item_sample;
      first_gap   = item_gap;
      first_kind  = KIND_PASS;
      first_last  = 1'b1;
    end else begin
      first_value = seen_next ? min_next : '0;
      first_gap   = ~seen_next;
      first_kind  = KIND_MIN;
      first_last  = 1'b0;
    end
  end

  // State update; a finished setup restarts the series.
  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      bucket_end   <= '0;
      boundary_rem <= '0;
      step_q       <= '0;
      step_r       <= '0;
      seen_valid   <= 1'b0;
    end else if (setup_done) begin
      position     <= '0;
      bucket_end   <= setup_quotient;
      boundary_rem <= setup_remainder;
      step_q       <= setup_quotient;
      step_r       <= setup_remainder;
      seen_valid   <= 1'b0;
    end else if (item_valid && decimating) begin
      if (bucket_hit) begin
        seen_valid <= 1'b0;
        if (series_end) begin
          position     <= '0;
          bucket_end   <= step_q;
          boundary_rem <= step_r;
        end else begin
          position     <= position_next;
          bucket_end   <= bucket_end_next;
          boundary_rem <= boundary_rem_next;
        end
      end else begin
        seen_valid <= seen_next;
        position   <= position_next;
      end
    end
  end

  // Extremes are only read while seen_valid is set.
  always_ff @(posedge clk) begin
    if (item_valid && decimating && !bucket_hit) begin
      running_min <= min_next;
      running_max <= max_next;
    end
  end

endmodule

FILE: rtl/mmbd_fifo.sv
// Result queue: takes up to two entries per cycle, hands out one.
// Uses RESULT_DEPTH from mmbd_pkg.
module mmbd_fifo
  import mmbd_pkg::*;
#(
  parameter int WIDTH = 36
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push_first,
  input  logic                            push_second,
  input  logic [WIDTH-1:0]                first_data,
  input  logic [WIDTH-1:0]                second_data,
  input  logic                            rd_take,
  output logic                            rd_valid,
  output logic [WIDTH-1:0]                rd_data,
  output logic [$clog2(RESULT_DEPTH):0]   count
);

  localparam int AW = $clog2(RESULT_DEPTH);

  logic [WIDTH-1:0] entries [RESULT_DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             pop;

  assign rd_valid = count != '0;
  assign rd_data  = entries[rd_ptr];
  assign pop      = rd_valid && rd_take;

  // Storage; the second entry lands right after the first.
  always_ff @(posedge clk) begin
    if (push_first) begin
      entries[wr_ptr] <= first_data;
    end
    if (push_second) begin
      entries[wr_ptr + AW'(1)] <= second_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push_first) + AW'(push_second);
      rd_ptr <= rd_ptr + AW'(pop);
      count  <= count + (AW + 1)'(push_first) + (AW + 1)'(push_second)
                - (AW + 1)'(pop);
    end
  end

endmodule

FILE: rtl/min_max_bucket_decimator_core.sv
// Channel   Direction  Signals                              Transaction when
// input     in         in_valid, in_stall, sample, is_gap   in_valid && !in_stall
// result    out        out_valid, out_stall, value,         out_valid && !out_stall
//                      value_gap, kind, last
// config    in         cfg_wr, cfg_idx, cfg_data            cfg_wr
//
// One sample is taken per cycle while in_stall is low; its results go from the input register into the queue.
// A bucket end gives two results, but every bucket holds at least two samples,
// so the one-per-cycle output keeps pace; the eight-entry queue absorbs bursts.
// A register write runs a bit-serial division for the bucket step, with in_stall
// high until it is done. Synchronous reset loads the empty-series setup at once.
// Top level of the min/max bucket decimator; uses mmbd_pkg, mmbd_div,
// mmbd_bucket and mmbd_fifo.
module min_max_bucket_decimator_core
  import mmbd_pkg::*;
#(
  parameter int SAMPLE_BITS = 32,
  parameter int COUNT_BITS  = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          is_gap,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] value,
  output logic                          value_gap,
  output logic [1:0]                    kind,
  output logic                          last,
  input  logic                          cfg_wr,
  input  cfg_idx_t                      cfg_idx,
  input  logic [COUNT_BITS:0]           cfg_data
);

  localparam int NW  = COUNT_BITS + 1;
  localparam int EW  = SAMPLE_BITS + 4;
  localparam int CW  = $clog2(RESULT_DEPTH) + 1;

  logic [NW-1:0]                 sample_count;
  logic [COUNT_BITS-1:0]         point_budget;
  logic                          setup_start;
  logic                          decimating;
  logic [COUNT_BITS-1:0]         bucket_total;
  logic                          div_busy;
  logic                          div_done;
  logic [NW-1:0]                 div_quotient;
  logic [COUNT_BITS-1:0]         div_remainder;

  logic                          in_held;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                          in_gap;
  logic                          accept;

  logic                          push_first;
  logic                          push_second;
  logic signed [SAMPLE_BITS-1:0] first_value;
  logic                          first_gap;
  kind_t                         first_kind;
  logic                          first_last;
  logic signed [SAMPLE_BITS-1:0] second_value;
  logic                          second_gap;
  logic [EW-1:0]                 first_entry;
  logic [EW-1:0]                 second_entry;
  logic [EW-1:0]                 head_entry;
  logic [CW-1:0]                 queue_count;
  logic [CW:0]                   queue_claim;

  // Configuration registers; a write to either register restarts the bucket setup.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      point_budget <= COUNT_BITS'(BUDGET_RESET);
      setup_start  <= 1'b0;
    end else begin
      setup_start <= 1'b0;
      if (cfg_wr) begin
        case (cfg_idx)
          REG_SAMPLE_COUNT: begin
            sample_count <= cfg_data;
            setup_start  <= 1'b1;
          end
          REG_POINT_BUDGET: begin
            point_budget <= cfg_data[COUNT_BITS-1:0];
            setup_start  <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Mode decision, registered off the configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      decimating <= 1'b0;
    end else begin
      decimating <= (point_budget != '0) && (sample_count > {1'b0, point_budget});
    end
  end

  // Number of buckets: half the budget, at least one.
  assign bucket_total = (point_budget[COUNT_BITS-1:1] == '0) ? COUNT_BITS'(1)
                                                            : {1'b0, point_budget[COUNT_BITS-1:1]};

  mmbd_div #(
    .COUNT_BITS(COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (setup_start),
    .dividend (sample_count),
    .divisor  (bucket_total),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient),
    .remainder(div_remainder)
  );

  // Input flow control: hold off during setup and when the queue could overflow.
  assign queue_claim = {1'b0, queue_count} + (in_held ? (CW + 1)'(MAX_PUSH) : '0);
  assign in_stall    = rst || setup_start || div_busy
                       || (queue_claim > (CW + 1)'(RESULT_DEPTH - MAX_PUSH));
  assign accept      = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else begin
      in_held <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_sample <= sample;
      in_gap    <= is_gap;
    end
  end

  mmbd_bucket #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_bucket (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (in_held),
    .item_sample    (in_sample),
    .item_gap       (in_gap),
    .decimating     (decimating),
    .sample_count   (sample_count),
    .bucket_total   (bucket_total),
    .setup_done     (div_done),
    .setup_quotient (div_quotient),
    .setup_remainder(div_remainder),
    .push_first     (push_first),
    .push_second    (push_second),
    .first_value    (first_value),
    .first_gap      (first_gap),
    .first_kind     (first_kind),
    .first_last     (first_last),
    .second_value   (second_value),
    .second_gap     (second_gap)
  );

  // Queue entries: value, gap flag, kind, last.
  assign first_entry  = {first_value, first_gap, first_kind, first_last};
  assign second_entry = {second_value, second_gap, KIND_MAX, 1'b1};

  mmbd_fifo #(
    .WIDTH(EW)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_first (push_first),
    .push_second(push_second),
    .first_data (first_entry),
    .second_data(second_entry),
    .rd_take    (!out_stall),
    .rd_valid   (out_valid),
    .rd_data    (head_entry),
    .count      (queue_count)
  );

  assign value     = head_entry[EW-1 -: SAMPLE_BITS];
  assign value_gap = head_entry[3];
  assign kind      = head_entry[2:1];
  assign last      = head_entry[0];

  // The queue never holds more than its depth.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    queue_count <= CW'(RESULT_DEPTH))
    else $error("result queue overflow");

  // A bucket minimum that leaves is followed at once by its maximum.
  a_min_then_max: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && kind == KIND_MIN) |=> (out_valid && kind == KIND_MAX))
    else $error("bucket maximum does not follow its minimum");

  // Only a bucket minimum is not the last result of its sample.
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (kind != KIND_MIN)))
    else $error("last flag does not match result kind");

endmodule

FILE: dv/min_max_bucket_decimator_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for min_max_bucket_decimator_core: sends samples with random
// idling on both channels, predicts passthrough and bucket min/max results, checks each.
// Depends on mmbd_pkg and the decimator RTL.
module min_max_bucket_decimator_core_tb;
  import mmbd_pkg::*;

  localparam int SAMPLE_W = 32;
  localparam int COUNT_W = 24;
  localparam int CLK_PERIOD = 20;
  localparam int SETTLE_CYCLES = 16;
  localparam logic [COUNT_W:0] COUNT_MAX = 25'h1000000;
  localparam logic [COUNT_W:0] BUDGET_MAX = 25'h0ffffff;
  // Indexes past the register list; writes to them must be dropped.
  localparam cfg_idx_t REG_SPARE_A = 2'd2;
  localparam cfg_idx_t REG_SPARE_B = 2'd3;

  // One expected result transaction.
  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    logic gap;
    kind_t kind;
    logic fin;
  } point_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] sample;
  logic is_gap;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] value;
  logic value_gap;
  logic [1:0] kind;
  logic last;
  logic cfg_wr;
  cfg_idx_t cfg_idx;
  logic [COUNT_W:0] cfg_data;

  int sender_idle_pct;
  int receiver_idle_pct;
  int fail_count = 0;
  int samples_sent = 0;

  point_t owed_points[$];

  // Predictor copy of the registers and the bucket state.
  logic [COUNT_W:0] series_len;
  logic [COUNT_W-1:0] budget;
  logic [COUNT_W:0] position;
  logic [COUNT_W+1:0] bucket_end;
  logic [COUNT_W-1:0] end_frac;
  logic [COUNT_W:0] step_whole;
  logic [COUNT_W-1:0] step_frac;
  logic signed [SAMPLE_W-1:0] lo;
  logic signed [SAMPLE_W-1:0] hi;
  logic any_valid;

  min_max_bucket_decimator_core #(
    .SAMPLE_BITS(SAMPLE_W),
    .COUNT_BITS(COUNT_W)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample(sample),
    .is_gap(is_gap),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .value(value),
    .value_gap(value_gap),
    .kind(kind),
    .last(last),
    .cfg_wr(cfg_wr),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Number of buckets the current budget asks for, never below one.
  function automatic logic [COUNT_W-1:0] bucket_count();
    return (budget >> 1) == '0 ? COUNT_W'(1) : budget >> 1;
  endfunction

  // Recompute the bucket step and start a fresh series.
  function automatic void restart_series();
    logic [COUNT_W-1:0] nb;
    nb = bucket_count();
    step_whole = series_len / nb;
    step_frac = COUNT_W'(series_len % nb);
    position = '0;
    bucket_end = {1'b0, step_whole};
    end_frac = step_frac;
    lo = '0;
    hi = '0;
    any_valid = 1'b0;
  endfunction

  function automatic void apply_reg(input cfg_idx_t idx, input logic [COUNT_W:0] data);
    case (idx)
      REG_SAMPLE_COUNT: series_len = data;
      REG_POINT_BUDGET: budget = data[COUNT_W-1:0];
      default: return;
    endcase
    restart_series();
  endfunction

  function automatic void owe_point(input logic signed [SAMPLE_W-1:0] v, input logic g,
                                    input kind_t k, input logic fin);
    point_t p;
    p.value = v;
    p.gap = g;
    p.kind = k;
    p.fin = fin;
    owed_points.push_back(p);
  endfunction

  // Work out the results that one accepted sample causes.
  function automatic void predict_sample(input logic signed [SAMPLE_W-1:0] s, input logic g);
    logic [COUNT_W-1:0] nb;
    if (budget == 0 || series_len <= budget) begin
      owe_point(g ? '0 : s, g, KIND_PASS, 1'b1);
      return;
    end
    if (!g) begin
      if (!any_valid || s < lo) lo = s;
      if (!any_valid || s > hi) hi = s;
      any_valid = 1'b1;
    end
    position = position + 1'b1;
    if (position < bucket_end) return;
    // Bucket closed: minimum first, then maximum; a gap-only bucket gives gaps.
    if (any_valid) begin
      owe_point(lo, 1'b0, KIND_MIN, 1'b0);
      owe_point(hi, 1'b0, KIND_MAX, 1'b1);
    end else begin
      owe_point('0, 1'b1, KIND_MIN, 1'b0);
      owe_point('0, 1'b1, KIND_MAX, 1'b1);
    end
    lo = '0;
    hi = '0;
    any_valid = 1'b0;
    nb = bucket_count();
    end_frac = end_frac + step_frac;
    bucket_end = bucket_end + step_whole;
    if (end_frac >= nb) begin
      end_frac = end_frac - nb;
      bucket_end = bucket_end + 1'b1;
    end
    if (position >= series_len) restart_series();
  endfunction

  // Receiver side: random stall at the configured rate.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_idle_pct);
  end

  // Compare every result transaction with the oldest expectation.
  always @(posedge clk) begin : check_results
    point_t want;
    if (!rst && out_valid && !out_stall) begin
      if (owed_points.size() == 0) begin
        $display("%0t: unexpected result value=%0d gap=%0b kind=%0d last=%0b",
                 $time, value, value_gap, kind, last);
        fail_count++;
      end else begin
        want = owed_points.pop_front();
        if (value !== want.value || value_gap !== want.gap || kind !== want.kind ||
            last !== want.fin) begin
          $display("%0t: mismatch: expected value=%0d gap=%0b kind=%0d last=%0b",
                   $time, want.value, want.gap, want.kind, want.fin);
          $display("%0t:           actual   value=%0d gap=%0b kind=%0d last=%0b",
                   $time, value, value_gap, kind, last);
          fail_count++;
        end
      end
    end
  end

  // Send one sample transaction, idling first at the sender's rate.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic g);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    is_gap <= g;
    do @(posedge clk); while (in_stall);
    predict_sample(s, g);
    samples_sent++;
  endtask

  // Hold off the sender until every expected result has arrived, then let the
  // block settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (owed_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register and wait out the bucket setup.
  task automatic write_reg(input cfg_idx_t idx, input logic [COUNT_W:0] data);
    cfg_wr <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_wr <= 1'b0;
    apply_reg(idx, data);
    do @(posedge clk); while (in_stall);
  endtask

  // Write both registers in random order once the block is idle.
  task automatic setup_series(input logic [COUNT_W:0] count, input logic [COUNT_W:0] bud);
    drain_results();
    if ($urandom_range(1)) begin
      write_reg(REG_SAMPLE_COUNT, count);
      write_reg(REG_POINT_BUDGET, bud);
    end else begin
      write_reg(REG_POINT_BUDGET, bud);
      write_reg(REG_SAMPLE_COUNT, count);
    end
  endtask

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $signed($urandom_range(8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_series(input int n, input int gap_pct);
    for (int i = 0; i < n; i++) begin
      send_sample(random_sample(), $urandom_range(99) < gap_pct);
    end
  endtask

  // After reset the series is empty, so every sample passes through.
  task automatic test_passthrough();
    send_sample(32'sh7fffffff, 1'b0);
    send_sample(32'sh80000000, 1'b0);
    send_sample(0, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(32'sh7fffffff, 1'b1);
    send_sample(32'sh80000000, 1'b1);
  endtask

  // Two uneven buckets, the second of only gaps, then samples past the series end.
  task automatic test_buckets();
    setup_series(5, 4);
    send_sample(5, 1'b0);
    send_sample(-3, 1'b0);
    send_sample(77, 1'b1);
    send_sample(-8, 1'b1);
    send_sample(0, 1'b1);
    send_sample(32'sh80000000, 1'b0);
    send_sample(32'sh7fffffff, 1'b0);
  endtask

  // Ignored register indexes, bits above a register's width, and a write that
  // drops a partly filled bucket.
  task automatic test_register_rules();
    setup_series(6, 1);
    send_sample(3, 1'b0);
    send_sample(-2, 1'b1);
    drain_results();
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, 25'h0aaaaaa);
    send_sample(10, 1'b0);
    send_sample(-20, 1'b1);
    send_sample(-20, 1'b0);
    send_sample(7, 1'b0);
    drain_results();
    write_reg(REG_POINT_BUDGET, 25'h1000003);
    send_sample(1, 1'b0);
    send_sample(2, 1'b0);
    drain_results();
    write_reg(REG_SAMPLE_COUNT, 4);
    send_sample(-5, 1'b0);
    send_sample(32'sh7fffffff, 1'b0);
    send_sample(0, 1'b1);
    send_sample(32'sh80000000, 1'b0);
  endtask

  // Register extremes with random content.
  task automatic test_extreme_settings();
    // Largest count and budget: buckets of two or three samples.
    setup_series(COUNT_MAX, BUDGET_MAX);
    run_series(40, 20);
    // A single bucket over the whole span never closes here.
    setup_series(COUNT_MAX, 1);
    run_series(12, 10);
    // Count equal to the budget, zero budget and zero count all pass through.
    setup_series(BUDGET_MAX, BUDGET_MAX);
    run_series(8, 20);
    setup_series(COUNT_MAX, 0);
    run_series(8, 20);
    setup_series(0, 2);
    run_series(4, 20);
  endtask

  // Random series, mostly decimating, with random gap density.
  task automatic test_random_series(input int quota);
    int start;
    int cnt;
    int bud;
    int n;
    int gap_pct;
    int pick;
    start = samples_sent;
    while (samples_sent - start < quota) begin
      pick = $urandom_range(99);
      if (pick < 70) cnt = $urandom_range(48, 1);
      else if (pick < 85) cnt = $urandom_range(120, 49);
      else cnt = $urandom_range(4, 0);
      pick = $urandom_range(99);
      if (pick < 65) bud = $urandom_range(cnt > 1 ? cnt - 1 : 1, 1);
      else if (pick < 75) bud = 0;
      else if (pick < 88) bud = cnt + $urandom_range(3);
      else bud = $urandom_range(16777215);
      case ($urandom_range(3))
        0: gap_pct = 0;
        1: gap_pct = 10;
        2: gap_pct = 35;
        default: gap_pct = 90;
      endcase
      if (bud != 0 && cnt > bud) n = cnt * $urandom_range(2, 1) + $urandom_range(3);
      else n = $urandom_range(20, 4);
      setup_series((COUNT_W + 1)'(cnt), (COUNT_W + 1)'(bud));
      run_series(n, gap_pct);
    end
  endtask

  // Main sequence.
  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    sample <= '0;
    is_gap <= 1'b0;
    cfg_wr <= 1'b0;
    cfg_idx <= REG_SAMPLE_COUNT;
    cfg_data <= '0;
    sender_idle_pct = 38;
    receiver_idle_pct = 75;
    series_len = '0;
    budget = COUNT_W'(BUDGET_RESET);
    restart_series();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_passthrough();
    test_buckets();
    test_register_rules();
    test_extreme_settings();
    test_random_series(170);
    sender_idle_pct = 75;
    receiver_idle_pct = 38;
    test_random_series(190);
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    test_random_series(170);

    drain_results();
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // Hang guard.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
